FILE: src/lcm_pkg.sv
// Package for the lattice cell metrics block: widths, result tags,
// the shared multiplier's control word and the adjugate operand table.
// No dependencies.
package lcm_pkg;

  localparam int FIELD_W      = 27;
  localparam int VOL_W        = 64;
  localparam int HALF_W       = 26;
  localparam int RECIP_W      = 64;
  localparam int MAX_COEF_DEF = 15;
  localparam int OP_W         = 29;
  localparam int PROD_W       = 2 * OP_W;
  localparam int ACC_W        = 96;
  localparam int ADJ_W        = 56;
  localparam int DET_SPLIT    = 28;
  localparam int DIV_W        = 88;
  localparam int NUM_W        = 128;
  localparam int FRAC_SH      = 48;
  localparam int SQ_W         = 56;
  localparam int ROOT_W       = 28;
  localparam int COMP_LIM     = 27;
  localparam int TAG_W        = 5;

  localparam logic [SQ_W-1:0] SQ_CAP = SQ_W'(1) << 54;

  localparam logic [TAG_W-1:0] TAG_ADJ = 5'd0;
  localparam logic [TAG_W-1:0] TAG_NM  = 5'd9;
  localparam logic [TAG_W-1:0] TAG_DET = 5'd18;
  localparam logic [TAG_W-1:0] TAG_SQ  = 5'd19;

  typedef struct packed {
    logic             issue;
    logic             clear;
    logic             sub;
    logic             shift;
    logic             last;
    logic [TAG_W-1:0] tag;
  } lcm_mac_ctl_t;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
  } lcm_mac_res_t;

  // Adjugate entry e = m[x1]*m[y1] - m[x2]*m[y2], packed {x1, y1, x2, y2}.
  function automatic logic [15:0] adj_idx(input logic [3:0] e);
    logic [15:0] r;
    case (e)
      4'd0:    r = {4'd4, 4'd8, 4'd5, 4'd7};
      4'd1:    r = {4'd2, 4'd7, 4'd1, 4'd8};
      4'd2:    r = {4'd1, 4'd5, 4'd2, 4'd4};
      4'd3:    r = {4'd5, 4'd6, 4'd3, 4'd8};
      4'd4:    r = {4'd0, 4'd8, 4'd2, 4'd6};
      4'd5:    r = {4'd2, 4'd3, 4'd0, 4'd5};
      4'd6:    r = {4'd3, 4'd7, 4'd4, 4'd6};
      4'd7:    r = {4'd1, 4'd6, 4'd0, 4'd7};
      4'd8:    r = {4'd0, 4'd4, 4'd1, 4'd3};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: src/lcm_if.sv
// Channel interfaces of the lattice cell metrics block: basis in, metrics out.
// Depends on lcm_pkg.
interface lcm_in_if;
  import lcm_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] basis_00;
  logic signed [FIELD_W-1:0] basis_01;
  logic signed [FIELD_W-1:0] basis_02;
  logic signed [FIELD_W-1:0] basis_10;
  logic signed [FIELD_W-1:0] basis_11;
  logic signed [FIELD_W-1:0] basis_12;
  logic signed [FIELD_W-1:0] basis_20;
  logic signed [FIELD_W-1:0] basis_21;
  logic signed [FIELD_W-1:0] basis_22;
  modport source (output valid, basis_00, basis_01, basis_02, basis_10, basis_11,
                  basis_12, basis_20, basis_21, basis_22, input ready);
  modport sink (input valid, basis_00, basis_01, basis_02, basis_10, basis_11,
                basis_12, basis_20, basis_21, basis_22, output ready);
endinterface

interface lcm_out_if;
  import lcm_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VOL_W-1:0]   cell_volume;
  logic        [HALF_W-1:0]  half_shortest;
  logic signed [RECIP_W-1:0] recip_00;
  logic signed [RECIP_W-1:0] recip_01;
  logic signed [RECIP_W-1:0] recip_02;
  logic signed [RECIP_W-1:0] recip_10;
  logic signed [RECIP_W-1:0] recip_11;
  logic signed [RECIP_W-1:0] recip_12;
  logic signed [RECIP_W-1:0] recip_20;
  logic signed [RECIP_W-1:0] recip_21;
  logic signed [RECIP_W-1:0] recip_22;
  logic                      cell_invalid;
  modport source (output valid, cell_volume, half_shortest, recip_00, recip_01,
                  recip_02, recip_10, recip_11, recip_12, recip_20, recip_21,
                  recip_22, cell_invalid, input ready);
  modport sink (input valid, cell_volume, half_shortest, recip_00, recip_01,
                recip_02, recip_10, recip_11, recip_12, recip_20, recip_21,
                recip_22, cell_invalid, output ready);
endinterface

FILE: src/lattice_cell_metrics.sv
// Lattice cell metrics: volume, reciprocal basis and half shortest lattice
// vector of a 3x3 basis. A word is taken only while the block is idle and
// returns one result word. One shared 29x29 multiply-accumulate unit computes
// the scaled basis, the adjugate (2 products per entry) and the determinant
// (6 products). A bit-serial divider then forms each reciprocal entry, after
// which the unit squares the three components of every search vector for each
// of (2*MAX_COEF+1)^3 coefficient triples, and a root unit finishes the cell.
// A cell with negative volume skips the search and the root, and a zero volume
// skips the division too. A finished word waits in the output register while
// the next basis is taken.
// Depends on lcm_pkg, lcm_if, lcm_mac, lcm_div and lcm_sqrt.
module lattice_cell_metrics #(
  parameter int MAX_COEF = lcm_pkg::MAX_COEF_DEF
) (
  input logic        clk,
  input logic        rst_n,
  lcm_in_if.sink     in_ch,
  lcm_out_if.source  out_ch
);
  import lcm_pkg::*;

  localparam int CW  = $clog2(MAX_COEF + 1) + 1;
  localparam int NMW = FIELD_W + $clog2(MAX_COEF + 1);
  localparam int CPW = $clog2(3 * MAX_COEF + 1) + FIELD_W + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_NM, S_ADJ, S_DET, S_DETW, S_DIVS, S_DIVW,
    S_SINIT, S_SQ, S_DRAIN, S_SQS, S_SQW, S_OUT
  } state_t;

  state_t                    state_r;
  logic [4:0]                cnt_r;
  logic signed [FIELD_W-1:0] m_r   [9];
  logic signed [ADJ_W-1:0]   adj_r [9];
  logic signed [NMW-1:0]     nm_r  [9];
  logic signed [ACC_W-1:0]   det_r;
  logic [RECIP_W-1:0]        recip_r [9];
  logic signed [CW-1:0]      ci_r, cj_r, ck_r;
  logic signed [CPW-1:0]     vi_r [3];
  logic signed [CPW-1:0]     vij_r[3];
  logic signed [CPW-1:0]     vc_r [3];
  logic [SQ_W-1:0]           best_r;
  logic                      flag_big_r;
  logic                      flag_zero_r;

  logic                      out_valid_r;
  logic signed [VOL_W-1:0]   vol_out_r;
  logic [HALF_W-1:0]         half_out_r;
  logic [RECIP_W-1:0]        recip_out_r [9];
  logic                      inv_out_r;

  lcm_mac_ctl_t              mctl;
  lcm_mac_res_t              mres;
  logic signed [OP_W-1:0]    op_a, op_b;
  logic signed [ACC_W-1:0]   acc;
  logic [15:0]               aidx;
  logic [1:0]                term;
  logic [3:0]                tidx;
  logic signed [ADJ_W-1:0]   adj_sel;
  logic [TAG_W-1:0]          nm_slot;
  logic [2:0]                big;
  logic                      det_zero;
  logic                      det_inv;
  logic                      div_start, div_done;
  logic [RECIP_W-1:0]        div_quo;
  logic                      sq_start, sq_done;
  logic [ROOT_W-1:0]         root;
  logic [SQ_W-1:0]           cand;
  logic [HALF_W-1:0]         half_val;
  logic                      last_triple;

  assign det_zero = (det_r == '0);
  assign det_inv  = det_zero | det_r[ACC_W-1];
  assign nm_slot  = mres.tag - TAG_NM;
  assign aidx     = adj_idx(cnt_r[4:1]);
  assign term     = cnt_r[2:1];
  assign tidx     = {term, 1'b0} + {2'b00, term};
  assign adj_sel  = adj_r[tidx];
  assign last_triple = ci_r == CW'(MAX_COEF) && cj_r == CW'(MAX_COEF) &&
                       ck_r == CW'(MAX_COEF);

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      big[p] = !(vc_r[p] < CPW'(1 << COMP_LIM) && vc_r[p] > -CPW'(1 << COMP_LIM));
    end
  end

  always_comb begin
    if (flag_big_r || acc[SQ_W-1:0] > SQ_CAP || acc[ACC_W-1:SQ_W] != '0) begin
      cand = SQ_CAP;
    end else begin
      cand = acc[SQ_W-1:0];
    end
  end

  assign half_val = det_inv ? '1 : (root[ROOT_W-1] ? '1 : root[HALF_W:1]);

  always_comb begin
    mctl = '0;
    op_a = '0;
    op_b = '0;
    unique case (state_r)
      S_NM: begin
        op_a       = OP_W'(MAX_COEF);
        op_b       = OP_W'(m_r[cnt_r[3:0]]);
        mctl.issue = 1'b1;
        mctl.clear = 1'b1;
        mctl.last  = 1'b1;
        mctl.tag   = TAG_NM + cnt_r;
      end
      S_ADJ: begin
        op_a       = cnt_r[0] ? OP_W'(m_r[aidx[7:4]]) : OP_W'(m_r[aidx[15:12]]);
        op_b       = cnt_r[0] ? OP_W'(m_r[aidx[3:0]]) : OP_W'(m_r[aidx[11:8]]);
        mctl.issue = 1'b1;
        mctl.clear = !cnt_r[0];
        mctl.sub   = cnt_r[0];
        mctl.last  = cnt_r[0];
        mctl.tag   = TAG_ADJ + {1'b0, cnt_r[4:1]};
      end
      S_DET: begin
        op_a       = OP_W'(m_r[{2'b00, term}]);
        op_b       = cnt_r[0] ? OP_W'($signed(adj_sel[ADJ_W-1:DET_SPLIT]))
                              : $signed({1'b0, adj_sel[DET_SPLIT-1:0]});
        mctl.issue = 1'b1;
        mctl.clear = cnt_r == 5'd0;
        mctl.shift = cnt_r[0];
        mctl.last  = cnt_r == 5'd5;
        mctl.tag   = TAG_DET;
      end
      S_SQ: begin
        op_a       = OP_W'($signed(vc_r[cnt_r[1:0]][COMP_LIM:0]));
        op_b       = OP_W'($signed(vc_r[cnt_r[1:0]][COMP_LIM:0]));
        mctl.issue = 1'b1;
        mctl.clear = cnt_r == 5'd0;
        mctl.last  = cnt_r == 5'd2;
        mctl.tag   = TAG_SQ;
      end
      default: ;
    endcase
  end

  assign div_start = (state_r == S_DIVS) && !det_zero;
  assign sq_start  = (state_r == S_SQS);

  always_ff @(posedge clk) begin
    if (mres.valid) begin
      if (mres.tag == TAG_DET) begin
        det_r <= acc;
      end else if (mres.tag == TAG_SQ) begin
        if (!flag_zero_r && cand < best_r) begin
          best_r <= cand;
        end
      end else if (mres.tag >= TAG_NM) begin
        nm_r[nm_slot[3:0]] <= acc[NMW-1:0];
      end else begin
        adj_r[mres.tag[3:0]] <= acc[ADJ_W-1:0];
      end
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            m_r[0]  <= in_ch.basis_00;
            m_r[1]  <= in_ch.basis_01;
            m_r[2]  <= in_ch.basis_02;
            m_r[3]  <= in_ch.basis_10;
            m_r[4]  <= in_ch.basis_11;
            m_r[5]  <= in_ch.basis_12;
            m_r[6]  <= in_ch.basis_20;
            m_r[7]  <= in_ch.basis_21;
            m_r[8]  <= in_ch.basis_22;
            cnt_r   <= '0;
            state_r <= S_NM;
          end
        end
        S_NM: begin
          cnt_r <= (cnt_r == 5'd8) ? '0 : cnt_r + 5'd1;
          if (cnt_r == 5'd8) state_r <= S_ADJ;
        end
        S_ADJ: begin
          cnt_r <= (cnt_r == 5'd17) ? '0 : cnt_r + 5'd1;
          if (cnt_r == 5'd17) state_r <= S_DET;
        end
        S_DET: begin
          cnt_r <= (cnt_r == 5'd5) ? '0 : cnt_r + 5'd1;
          if (cnt_r == 5'd5) state_r <= S_DETW;
        end
        S_DETW: begin
          if (mres.valid && mres.tag == TAG_DET) begin
            cnt_r   <= '0;
            state_r <= S_DIVS;
          end
        end
        S_DIVS: begin
          if (det_zero) begin
            for (int e = 0; e < 9; e++) recip_r[e] <= '0;
            state_r <= S_OUT;
          end else begin
            state_r <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            recip_r[cnt_r[3:0]] <= div_quo;
            if (cnt_r == 5'd8) begin
              state_r <= det_inv ? S_OUT : S_SINIT;
            end else begin
              cnt_r   <= cnt_r + 5'd1;
              state_r <= S_DIVS;
            end
          end
        end
        S_SINIT: begin
          for (int p = 0; p < 3; p++) begin
            vi_r[p]  <= -CPW'(nm_r[p]);
            vij_r[p] <= -CPW'(nm_r[p]) - CPW'(nm_r[p+3]);
            vc_r[p]  <= -CPW'(nm_r[p]) - CPW'(nm_r[p+3]) - CPW'(nm_r[p+6]);
          end
          ci_r    <= CW'(-MAX_COEF);
          cj_r    <= CW'(-MAX_COEF);
          ck_r    <= CW'(-MAX_COEF);
          best_r  <= SQ_CAP;
          cnt_r   <= '0;
          state_r <= S_SQ;
        end
        S_SQ: begin
          if (cnt_r == 5'd2) begin
            cnt_r       <= '0;
            flag_big_r  <= |big;
            flag_zero_r <= ci_r == '0 && cj_r == '0 && ck_r == '0;
            if (ck_r != CW'(MAX_COEF)) begin
              ck_r <= ck_r + CW'(1);
              for (int p = 0; p < 3; p++) vc_r[p] <= vc_r[p] + CPW'(m_r[p+6]);
            end else if (cj_r != CW'(MAX_COEF)) begin
              cj_r <= cj_r + CW'(1);
              ck_r <= CW'(-MAX_COEF);
              for (int p = 0; p < 3; p++) begin
                vij_r[p] <= vij_r[p] + CPW'(m_r[p+3]);
                vc_r[p]  <= vij_r[p] + CPW'(m_r[p+3]) - CPW'(nm_r[p+6]);
              end
            end else if (!last_triple) begin
              ci_r <= ci_r + CW'(1);
              cj_r <= CW'(-MAX_COEF);
              ck_r <= CW'(-MAX_COEF);
              for (int p = 0; p < 3; p++) begin
                vi_r[p]  <= vi_r[p] + CPW'(m_r[p]);
                vij_r[p] <= vi_r[p] + CPW'(m_r[p]) - CPW'(nm_r[p+3]);
                vc_r[p]  <= vi_r[p] + CPW'(m_r[p]) - CPW'(nm_r[p+3])
                            - CPW'(nm_r[p+6]);
              end
            end else begin
              state_r <= S_DRAIN;
            end
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_DRAIN: begin
          if (mres.valid && mres.tag == TAG_SQ) state_r <= S_SQS;
        end
        S_SQS: state_r <= S_SQW;
        S_SQW: begin
          if (sq_done) state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            vol_out_r   <= det_r[VOL_W+31:32];
            half_out_r  <= half_val;
            recip_out_r <= recip_r;
            inv_out_r   <= det_inv;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  lcm_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (mctl),
    .op_a  (op_a),
    .op_b  (op_b),
    .res_o (mres),
    .acc_o (acc)
  );

  lcm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .adj   (adj_r[cnt_r[3:0]]),
    .det   (det_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  lcm_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .x     (best_r),
    .done  (sq_done),
    .root  (root)
  );

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.cell_volume   = vol_out_r;
  assign out_ch.half_shortest = half_out_r;
  assign out_ch.recip_00      = recip_out_r[0];
  assign out_ch.recip_01      = recip_out_r[1];
  assign out_ch.recip_02      = recip_out_r[2];
  assign out_ch.recip_10      = recip_out_r[3];
  assign out_ch.recip_11      = recip_out_r[4];
  assign out_ch.recip_12      = recip_out_r[5];
  assign out_ch.recip_20      = recip_out_r[6];
  assign out_ch.recip_21      = recip_out_r[7];
  assign out_ch.recip_22      = recip_out_r[8];
  assign out_ch.cell_invalid  = inv_out_r;

  a_sq_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    mres.valid && mres.tag == TAG_SQ |-> state_r == S_SQ || state_r == S_DRAIN)
    else $error("search result outside search");

  a_div_in_phase: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIVW)
    else $error("divider finished outside division phase");

  a_invalid_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.cell_invalid |-> out_ch.half_shortest == '1)
    else $error("invalid cell without saturated cutoff");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result word raised outside output state");

endmodule

FILE: src/lcm_mac.sv
// Shared multiply-accumulate unit: registered product, then 96-bit accumulate.
// Depends on lcm_pkg.
module lcm_mac (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lcm_pkg::lcm_mac_ctl_t        ctl_i,
  input  logic signed [lcm_pkg::OP_W-1:0]  op_a,
  input  logic signed [lcm_pkg::OP_W-1:0]  op_b,
  output lcm_pkg::lcm_mac_res_t        res_o,
  output logic signed [lcm_pkg::ACC_W-1:0] acc_o
);
  import lcm_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  lcm_mac_ctl_t             c1_r;
  logic signed [ACC_W-1:0]  acc_r;
  lcm_mac_res_t             res_r;
  logic signed [ACC_W-1:0]  ext;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  base;

  assign ext    = ACC_W'(prod_r);
  assign addend = c1_r.shift ? (ext <<< DET_SPLIT) : ext;
  assign base   = c1_r.clear ? '0 : acc_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (c1_r.issue) begin
      acc_r <= c1_r.sub ? base - addend : base + addend;
    end
    if (!rst_n) begin
      c1_r  <= '0;
      res_r <= '0;
    end else begin
      c1_r        <= ctl_i;
      res_r.valid <= c1_r.issue & c1_r.last;
      res_r.tag   <= c1_r.tag;
    end
  end

  assign res_o = res_r;
  assign acc_o = acc_r;
endmodule

FILE: src/lcm_div.sv
// Restoring divider, one quotient bit per cycle: (adj << 48) / det, saturated.
// Depends on lcm_pkg.
module lcm_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [lcm_pkg::ADJ_W-1:0] adj,
  input  logic signed [lcm_pkg::ACC_W-1:0] det,
  output logic                             done,
  output logic [lcm_pkg::RECIP_W-1:0]      quo
);
  import lcm_pkg::*;

  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] q_r;
  logic [DIV_W-1:0] d_r;
  logic [DIV_W-1:0] rem_r;
  logic [6:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic             neg_r;
  logic [ADJ_W-1:0] adj_mag;
  logic [ACC_W-1:0] det_mag;
  logic [DIV_W-1:0] rem_sh;
  logic             ge;

  assign adj_mag = adj[ADJ_W-1] ? ADJ_W'(-adj) : ADJ_W'(adj);
  assign det_mag = det[ACC_W-1] ? ACC_W'(-det) : ACC_W'(det);
  assign rem_sh  = {rem_r[DIV_W-2:0], num_r[NUM_W-1]};
  assign ge      = rem_sh >= d_r;

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= {(NUM_W-ADJ_W-FRAC_SH)'(0), adj_mag, FRAC_SH'(0)};
      d_r   <= det_mag[DIV_W-1:0];
      rem_r <= '0;
      q_r   <= '0;
      neg_r <= adj[ADJ_W-1] ^ det[ACC_W-1];
    end else if (busy_r) begin
      rem_r <= ge ? rem_sh - d_r : rem_sh;
      q_r   <= {q_r[NUM_W-2:0], ge};
      num_r <= num_r << 1;
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd127) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (!neg_r) begin
      quo = (q_r[NUM_W-1:RECIP_W-1] != '0) ? {1'b0, {(RECIP_W-1){1'b1}}}
                                            : q_r[RECIP_W-1:0];
    end else if (q_r[NUM_W-1:RECIP_W] != '0 ||
                 (q_r[RECIP_W-1] && q_r[RECIP_W-2:0] != '0)) begin
      quo = {1'b1, {(RECIP_W-1){1'b0}}};
    end else begin
      quo = RECIP_W'(-q_r[RECIP_W-1:0]);
    end
  end

  assign done = done_r;
endmodule

FILE: src/lcm_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on lcm_pkg.
module lcm_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lcm_pkg::SQ_W-1:0]   x,
  output logic                       done,
  output logic [lcm_pkg::ROOT_W-1:0] root
);
  import lcm_pkg::*;

  logic [SQ_W-1:0] x_r;
  logic [SQ_W-1:0] r_r;
  logic [SQ_W-1:0] bit_r;
  logic            busy_r;
  logic            done_r;
  logic [SQ_W-1:0] trial;

  assign trial = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x;
      r_r   <= '0;
      bit_r <= SQ_W'(1) << 54;
    end else if (busy_r) begin
      if (x_r >= trial) begin
        x_r <= x_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign root = r_r[ROOT_W-1:0];
endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Testbench for lattice_cell_metrics: drives bases, predicts every metrics word
// and checks it field by field in a small scoreboard class.
// Depends on lcm_pkg, lcm_if and the lattice_cell_metrics RTL.
module tb;
  import lcm_pkg::*;

  localparam int  COEF      = MAX_COEF_DEF;
  localparam longint LIMIT  = 40_000_000;
  localparam int  N_RANDOM  = 100;

  typedef logic signed [FIELD_W-1:0] basis_t [9];

  typedef struct {
    logic signed [VOL_W-1:0]   vol;
    logic        [HALF_W-1:0]  half;
    logic signed [RECIP_W-1:0] recip [9];
    logic                      invalid;
  } metrics_t;

  function automatic logic signed [127:0] basis_det(basis_t b, output longint adj [3][3]);
    longint m [3][3];
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        m[r][c] = b[r*3+c];
    adj[0][0] = m[1][1]*m[2][2] - m[1][2]*m[2][1];
    adj[0][1] = m[0][2]*m[2][1] - m[0][1]*m[2][2];
    adj[0][2] = m[0][1]*m[1][2] - m[0][2]*m[1][1];
    adj[1][0] = m[1][2]*m[2][0] - m[1][0]*m[2][2];
    adj[1][1] = m[0][0]*m[2][2] - m[0][2]*m[2][0];
    adj[1][2] = m[0][2]*m[1][0] - m[0][0]*m[1][2];
    adj[2][0] = m[1][0]*m[2][1] - m[1][1]*m[2][0];
    adj[2][1] = m[0][1]*m[2][0] - m[0][0]*m[2][1];
    adj[2][2] = m[0][0]*m[1][1] - m[0][1]*m[1][0];
    return 128'(m[0][0]) * 128'(adj[0][0]) + 128'(m[0][1]) * 128'(adj[1][0])
         + 128'(m[0][2]) * 128'(adj[2][0]);
  endfunction

  function automatic logic [HALF_W-1:0] half_shortest_of(basis_t b);
    longint unsigned best, s, u, x, root, bit_w;
    longint cmp;
    logic big;
    best = 64'(SQ_CAP);
    for (int i = -COEF; i <= COEF; i++)
      for (int j = -COEF; j <= COEF; j++)
        for (int k = -COEF; k <= COEF; k++) begin
          if (i == 0 && j == 0 && k == 0) continue;
          s = 0;
          big = 0;
          for (int p = 0; p < 3; p++) begin
            cmp = longint'(i) * b[p] + longint'(j) * b[3+p] + longint'(k) * b[6+p];
            u = cmp < 0 ? -cmp : cmp;
            if (u >= (64'd1 << COMP_LIM)) big = 1;
            else s += u * u;
          end
          if (big || s > 64'(SQ_CAP)) s = 64'(SQ_CAP);
          if (s < best) best = s;
        end
    x = best;
    root = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > x) bit_w >>= 2;
    while (bit_w != 0) begin
      if (x >= root + bit_w) begin
        x -= root + bit_w;
        root = (root >> 1) + bit_w;
      end else begin
        root >>= 1;
      end
      bit_w >>= 2;
    end
    root >>= 1;
    return root > 64'h3FFFFFF ? 26'h3FFFFFF : root[HALF_W-1:0];
  endfunction

  class metrics_board;
    metrics_t pending_q [$];
    int errors, n_valid, n_neg, n_zero, n_seen;

    function void note_basis(basis_t b);
      metrics_t e;
      longint adj [3][3];
      logic signed [127:0] det;
      logic [127:0] num, dmag, q;
      logic neg;
      det = basis_det(b, adj);
      e.vol = det[95:32];
      e.invalid = (det <= 0);
      if (det > 0) n_valid++;
      else if (det < 0) n_neg++;
      else n_zero++;
      e.half = e.invalid ? 26'h3FFFFFF : half_shortest_of(b);
      dmag = det < 0 ? -det : det;
      for (int n = 0; n < 9; n++) begin
        if (det == 0) begin
          e.recip[n] = '0;
        end else begin
          neg = (adj[n/3][n%3] < 0) != (det < 0);
          num = 128'(adj[n/3][n%3] < 0 ? -adj[n/3][n%3] : adj[n/3][n%3]) << FRAC_SH;
          q = num / dmag;
          if (!neg) e.recip[n] = (q > 128'h7FFFFFFFFFFFFFFF) ? 64'h7FFFFFFFFFFFFFFF : q[63:0];
          else e.recip[n] = (q > 128'h8000000000000000) ? 64'h8000000000000000 : -q[63:0];
        end
      end
      pending_q.push_back(e);
    endfunction

    function void check_word(metrics_t a);
      metrics_t e;
      n_seen++;
      if (pending_q.size() == 0) begin
        $error("metrics word with nothing expected");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (a.vol !== e.vol) begin
        $error("cell_volume exp %h got %h", e.vol, a.vol); errors++;
      end
      if (a.half !== e.half) begin
        $error("half_shortest exp %h got %h", e.half, a.half); errors++;
      end
      if (a.invalid !== e.invalid) begin
        $error("cell_invalid exp %b got %b", e.invalid, a.invalid); errors++;
      end
      for (int n = 0; n < 9; n++)
        if (a.recip[n] !== e.recip[n]) begin
          $error("recip_%0d%0d exp %h got %h", n/3, n%3, e.recip[n], a.recip[n]);
          errors++;
        end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  lcm_in_if  in_ch();
  lcm_out_if out_ch();
  metrics_board board = new();
  longint cycles = 0;
  int hold = 0;
  bit quiet = 0;

  lattice_cell_metrics dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always #6 clk = ~clk;

  always @(posedge clk) begin
    metrics_t w;
    cycles++;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      w.vol = out_ch.cell_volume;
      w.half = out_ch.half_shortest;
      w.invalid = out_ch.cell_invalid;
      w.recip = '{out_ch.recip_00, out_ch.recip_01, out_ch.recip_02,
                  out_ch.recip_10, out_ch.recip_11, out_ch.recip_12,
                  out_ch.recip_20, out_ch.recip_21, out_ch.recip_22};
      board.check_word(w);
      hold = quiet ? 0 : $urandom_range(0, 5);
    end
  end

  always @(negedge clk) begin
    if (hold > 0) begin
      out_ch.ready = 0;
      hold--;
    end else begin
      out_ch.ready = 1;
    end
  end

  task automatic send_basis(basis_t b);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    repeat (gap) @(negedge clk);
    in_ch.valid = 1;
    {in_ch.basis_00, in_ch.basis_01, in_ch.basis_02} = {b[0], b[1], b[2]};
    {in_ch.basis_10, in_ch.basis_11, in_ch.basis_12} = {b[3], b[4], b[5]};
    {in_ch.basis_20, in_ch.basis_21, in_ch.basis_22} = {b[6], b[7], b[8]};
    do @(posedge clk); while (!in_ch.ready);
    board.note_basis(b);
    @(negedge clk);
    in_ch.valid = 0;
  endtask

  task automatic drain;
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic signed [FIELD_W-1:0] any_field();
    return FIELD_W'($urandom);
  endfunction

  function automatic logic signed [FIELD_W-1:0] modest_field();
    return FIELD_W'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
  endfunction

  localparam logic signed [FIELD_W-1:0] ONE  = 27'sd65536;
  localparam logic signed [FIELD_W-1:0] FMAX = 27'sh3FFFFFF;
  localparam logic signed [FIELD_W-1:0] FMIN = -27'sh4000000;

  initial begin
    basis_t b;
    basis_t dir [$];
    longint adj [3][3];
    int kind;
    in_ch.valid = 0;
    {in_ch.basis_00, in_ch.basis_01, in_ch.basis_02} = '0;
    {in_ch.basis_10, in_ch.basis_11, in_ch.basis_12} = '0;
    {in_ch.basis_20, in_ch.basis_21, in_ch.basis_22} = '0;
    out_ch.ready = 0;
    repeat (7) @(negedge clk);
    rst_n = 1;

    dir.push_back('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
    dir.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    dir.push_back('{FMAX, 0, 0, 0, FMAX, 0, 0, 0, FMAX});
    dir.push_back('{FMIN, 0, 0, 0, FMIN, 0, 0, 0, FMIN});
    dir.push_back('{FMIN, 0, 0, 0, FMIN, 0, 0, 0, ONE});
    dir.push_back('{1, 0, 0, 0, 1, 0, 0, 0, 1});
    dir.push_back('{FMAX, FMAX-1, 0, FMAX-1, FMAX-2, 0, 0, 0, 1});
    dir.push_back('{FMAX-1, FMAX-2, 0, FMAX, FMAX-1, 0, 0, 0, 1});
    dir.push_back('{ONE, ONE, 0, 0, ONE, ONE, ONE, 0, ONE});
    dir.push_back('{0, ONE, 0, ONE, 0, 0, 0, 0, ONE});
    dir.push_back('{ONE, 2, 3, ONE, 2, 3, 5, 7, 9});
    dir.push_back('{FMAX, FMIN, FMAX, FMIN, FMAX, FMIN, FMAX, FMAX, FMIN});
    dir.push_back('{FMIN, FMIN, FMIN, FMAX, FMAX, FMAX, 1, -1, 1});
    dir.push_back('{-1, -1, -1, -1, -1, -1, -1, -1, -1});
    foreach (dir[n]) send_basis(dir[n]);
    drain();

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 20 == 0) quiet = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      foreach (b[f]) b[f] = (kind < 3) ? any_field() : modest_field();
      if (kind >= 6 && kind < 8) begin
        for (int f = 0; f < 3; f++) b[6+f] = (kind == 6) ? b[f] : 0;
      end else if (basis_det(b, adj) < 0 && (kind >= 8 || kind == 0)) begin
        for (int f = 0; f < 3; f++) begin
          b[f] = b[f] ^ b[3+f];
          b[3+f] = b[f] ^ b[3+f];
          b[f] = b[f] ^ b[3+f];
        end
      end else if (basis_det(b, adj) > 0 && kind >= 3 && kind < 6) begin
        for (int f = 0; f < 3; f++) begin
          b[f] = b[f] ^ b[3+f];
          b[3+f] = b[f] ^ b[3+f];
          b[f] = b[f] ^ b[3+f];
        end
      end
      send_basis(b);
      if (n == N_RANDOM / 2) drain();
    end

    quiet = 0;
    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d cells: %0d positive, %0d negative, %0d singular volume",
             board.n_seen, board.n_valid, board.n_neg, board.n_zero);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
